// ===== rtl/mcst_pkg.sv =====
// Package for the MIDI channel state tracker: types, codes and fixed sizes.
// Used by mcst_note_mem, mcst_ctrl, mcst_datapath and midi_channel_state_tracker.
`default_nettype none

package mcst_pkg;

  localparam int NOTE_COUNT       = 128;
  localparam int CONTROLLER_COUNT = 32;
  localparam int NOTE_AW          = $clog2(NOTE_COUNT);
  localparam int CTL_AW           = $clog2(CONTROLLER_COUNT);
  localparam int DATA_W           = 7;
  localparam int VALUE_W          = 14;
  localparam int INDEX_W          = 9;

  // Input item kinds.
  localparam logic [1:0] KIND_MESSAGE     = 2'd0;
  localparam logic [1:0] KIND_READ_AXIS   = 2'd1;
  localparam logic [1:0] KIND_READ_SWITCH = 2'd2;

  // Result event kinds.
  localparam logic [2:0] EV_AXIS      = 3'd0;
  localparam logic [2:0] EV_SWITCH    = 3'd1;
  localparam logic [2:0] EV_VEL_CLEAR = 3'd2;
  localparam logic [2:0] EV_AFT_SET   = 3'd3;
  localparam logic [2:0] EV_READ      = 3'd4;

  // Upper nibble of the status byte.
  localparam logic [3:0] FN_NOTE_OFF   = 4'h8;
  localparam logic [3:0] FN_NOTE_ON    = 4'h9;
  localparam logic [3:0] FN_POLY_PRESS = 4'hA;
  localparam logic [3:0] FN_CONTROL    = 4'hB;
  localparam logic [3:0] FN_PROGRAM    = 4'hC;
  localparam logic [3:0] FN_CHAN_PRESS = 4'hD;
  localparam logic [3:0] FN_PITCH      = 4'hE;

  // Controller number ranges, by bits 6..5 of the controller number.
  localparam logic [1:0] CC_MSB    = 2'd0;
  localparam logic [1:0] CC_LSB    = 2'd1;
  localparam logic [1:0] CC_SWITCH = 2'd2;
  localparam logic [1:0] CC_HIGH   = 2'd3;

  localparam logic [DATA_W-1:0]  CC_ALL_OFF_MIN = 7'h7B;
  localparam logic [CTL_AW-1:0]  CTL_VOLUME     = 5'd7;
  localparam logic [CTL_AW-1:0]  CTL_BALANCE    = 5'd8;
  localparam logic [CTL_AW-1:0]  CTL_PAN        = 5'd10;
  localparam logic [VALUE_W-1:0] VALUE_FULL     = 14'h3FFF;
  localparam logic [VALUE_W-1:0] VALUE_CENTRE   = 14'(32'h40 << 7);

  localparam logic [INDEX_W-1:0] AXIS_VEL_BASE = 9'h000;
  localparam logic [INDEX_W-1:0] AXIS_AFT_BASE = 9'h080;
  localparam logic [INDEX_W-1:0] AXIS_CTL_BASE = 9'h100;
  localparam logic [INDEX_W-1:0] AXIS_PITCH    = 9'h120;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } mcst_cmd_t;

  typedef struct packed {
    logic out_busy;
  } mcst_status_t;

endpackage

`default_nettype wire

// ===== rtl/mcst_note_mem.sv =====
// Per-note store of 7-bit values with one registered read port and one write port.
// A group fill works through per-entry valid bits; depends on mcst_pkg.
`default_nettype none

module mcst_note_mem (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rd_en,
  input  wire logic [mcst_pkg::NOTE_AW-1:0]  rd_addr,
  output logic      [mcst_pkg::DATA_W-1:0]   rd_data,
  input  wire logic                          wr_en,
  input  wire logic [mcst_pkg::NOTE_AW-1:0]  wr_addr,
  input  wire logic [mcst_pkg::DATA_W-1:0]   wr_data,
  input  wire logic                          fill_en,
  input  wire logic [mcst_pkg::DATA_W-1:0]   fill_data
);

  logic [mcst_pkg::DATA_W-1:0]     mem [mcst_pkg::NOTE_COUNT];
  logic [mcst_pkg::NOTE_COUNT-1:0] valid;
  logic [mcst_pkg::DATA_W-1:0]     fill;
  logic [mcst_pkg::DATA_W-1:0]     mem_q;
  logic                            hit_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // An entry that is not valid holds the last group fill value.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill  <= '0;
      hit_q <= 1'b0;
    end else begin
      if (fill_en) begin
        valid <= '0;
        fill  <= fill_data;
      end else if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_q <= valid[rd_addr];
      end
    end
  end

  assign rd_data = hit_q ? mem_q : fill;

endmodule

`default_nettype wire

// ===== rtl/mcst_ctrl.sv =====
// Controller state machine for the MIDI channel state tracker.
// Issues capture and commit commands to mcst_datapath; depends on mcst_pkg.
`default_nettype none

module mcst_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire mcst_pkg::mcst_status_t status,
  output mcst_pkg::mcst_cmd_t        cmd
);

  mcst_pkg::state_t state;
  mcst_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      mcst_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = mcst_pkg::ST_APPLY;
        end
      end
      mcst_pkg::ST_APPLY: begin
        // The item waits here while a previous result still holds the output.
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = mcst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mcst_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");

  a_capture_then_apply: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == mcst_pkg::ST_APPLY && !in_ready)
    else $error("captured item not held for apply");

  a_commit_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> in_ready)
    else $error("block not ready after commit");
`endif

endmodule

`default_nettype wire

// ===== rtl/mcst_datapath.sv =====
// Datapath of the MIDI channel state tracker: input latch, note stores,
// controller and switch registers, result decode and output register.
// Depends on mcst_pkg and mcst_note_mem.
`default_nettype none

module mcst_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mcst_pkg::mcst_cmd_t           cmd,
  output mcst_pkg::mcst_status_t             status,
  input  wire logic [1:0]                    kind,
  input  wire logic [7:0]                    status_byte,
  input  wire logic [mcst_pkg::DATA_W-1:0]   data_first,
  input  wire logic [mcst_pkg::DATA_W-1:0]   data_second,
  input  wire logic [1:0]                    byte_count,
  input  wire logic [mcst_pkg::INDEX_W-1:0]  read_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         event_kind,
  output logic [mcst_pkg::INDEX_W-1:0]       index,
  output logic [mcst_pkg::VALUE_W-1:0]       value,
  output logic                               centered
);

  localparam int PAD_W = mcst_pkg::VALUE_W - mcst_pkg::DATA_W;

  // Captured item.
  logic [1:0]                       kind_q;
  logic [3:0]                       func_q;
  logic [mcst_pkg::DATA_W-1:0]      d0_q;
  logic [mcst_pkg::DATA_W-1:0]      d1_q;
  logic [mcst_pkg::INDEX_W-1:0]     ridx_q;

  logic [mcst_pkg::DATA_W-1:0]      d0_in;
  logic [mcst_pkg::DATA_W-1:0]      d1_in;
  logic [mcst_pkg::NOTE_AW-1:0]     note_rd_addr;

  // Channel state held in flip-flops.
  logic [mcst_pkg::VALUE_W-1:0]          ctl [mcst_pkg::CONTROLLER_COUNT];
  logic [mcst_pkg::CONTROLLER_COUNT-1:0] sw;
  logic [mcst_pkg::DATA_W-1:0]           program_number;
  logic [mcst_pkg::VALUE_W-1:0]          pitch_bend;

  logic [mcst_pkg::DATA_W-1:0]      vel_rd;
  logic [mcst_pkg::DATA_W-1:0]      prs_rd;

  // Decoded effects of the captured item.
  logic                             vel_wr;
  logic [mcst_pkg::DATA_W-1:0]      vel_wr_data;
  logic                             vel_clear;
  logic                             prs_wr;
  logic                             prs_fill;
  logic                             ctl_wr;
  logic [mcst_pkg::CTL_AW-1:0]      ctl_sel;
  logic [mcst_pkg::VALUE_W-1:0]     ctl_cur;
  logic [mcst_pkg::VALUE_W-1:0]     ctl_new;
  logic                             sw_wr;
  logic                             prog_wr;
  logic                             pitch_wr;
  logic [mcst_pkg::VALUE_W-1:0]     pitch_new;
  logic                             res_valid;
  logic [2:0]                       res_kind;
  logic [mcst_pkg::INDEX_W-1:0]     res_index;
  logic [mcst_pkg::VALUE_W-1:0]     res_value;
  logic                             res_signed;
  logic                             vel_we;
  logic                             prs_we;

  // Data bytes beyond the message length read as zero.
  assign d0_in = (byte_count >= 2'd2) ? data_first  : '0;
  assign d1_in = (byte_count >= 2'd3) ? data_second : '0;
  assign note_rd_addr = (kind == mcst_pkg::KIND_MESSAGE) ? d0_in
                                                         : read_index[mcst_pkg::NOTE_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      func_q <= status_byte[7:4];
      d0_q   <= d0_in;
      d1_q   <= d1_in;
      ridx_q <= read_index;
    end
  end

  assign vel_we = cmd.commit && vel_wr;
  assign prs_we = cmd.commit && prs_wr;

  mcst_note_mem u_vel_mem (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (cmd.capture),
    .rd_addr   (note_rd_addr),
    .rd_data   (vel_rd),
    .wr_en     (vel_we),
    .wr_addr   (d0_q),
    .wr_data   (vel_wr_data),
    .fill_en   (cmd.commit && vel_clear),
    .fill_data ('0)
  );

  mcst_note_mem u_prs_mem (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (cmd.capture),
    .rd_addr   (note_rd_addr),
    .rd_data   (prs_rd),
    .wr_en     (prs_we),
    .wr_addr   (d0_q),
    .wr_data   (d1_q),
    .fill_en   (cmd.commit && prs_fill),
    .fill_data (d0_q)
  );

  // Messages address a controller by their first data byte, axis reads by the index.
  assign ctl_sel = (kind_q == mcst_pkg::KIND_MESSAGE) ? d0_q[mcst_pkg::CTL_AW-1:0]
                                                      : ridx_q[mcst_pkg::CTL_AW-1:0];
  assign ctl_cur = ctl[ctl_sel];

  always_comb begin
    vel_wr      = 1'b0;
    vel_wr_data = '0;
    vel_clear   = 1'b0;
    prs_wr      = 1'b0;
    prs_fill    = 1'b0;
    ctl_wr      = 1'b0;
    ctl_new     = '0;
    sw_wr       = 1'b0;
    prog_wr     = 1'b0;
    pitch_wr    = 1'b0;
    pitch_new   = {d1_q, d0_q};
    res_valid   = 1'b0;
    res_kind    = mcst_pkg::EV_AXIS;
    res_index   = '0;
    res_value   = '0;
    res_signed  = 1'b0;

    case (kind_q)
      mcst_pkg::KIND_MESSAGE: begin
        case (func_q) inside
          mcst_pkg::FN_NOTE_OFF, mcst_pkg::FN_NOTE_ON: begin
            vel_wr      = 1'b1;
            vel_wr_data = (func_q == mcst_pkg::FN_NOTE_ON) ? d1_q : '0;
            res_valid   = 1'b1;
            res_index   = mcst_pkg::AXIS_VEL_BASE | {2'b00, d0_q};
            res_value   = {{PAD_W{1'b0}}, vel_wr_data};
          end
          mcst_pkg::FN_POLY_PRESS: begin
            prs_wr    = 1'b1;
            res_valid = 1'b1;
            res_index = mcst_pkg::AXIS_AFT_BASE | {2'b00, d0_q};
            res_value = {{PAD_W{1'b0}}, d1_q};
          end
          mcst_pkg::FN_CONTROL: begin
            case (d0_q[6:5]) inside
              mcst_pkg::CC_MSB, mcst_pkg::CC_LSB: begin
                ctl_wr = 1'b1;
                if (d0_q[6:5] == mcst_pkg::CC_MSB) begin
                  ctl_new = {d1_q, ctl_cur[mcst_pkg::DATA_W-1:0]};
                end else begin
                  ctl_new = {ctl_cur[mcst_pkg::VALUE_W-1:mcst_pkg::DATA_W], d1_q};
                end
                res_valid  = 1'b1;
                res_index  = mcst_pkg::AXIS_CTL_BASE | {4'b0000, ctl_sel};
                res_value  = ctl_new;
                res_signed = (ctl_sel == mcst_pkg::CTL_BALANCE) ||
                             (ctl_sel == mcst_pkg::CTL_PAN);
              end
              mcst_pkg::CC_SWITCH: begin
                // A switch is on when the value is 64 or more.
                sw_wr     = 1'b1;
                res_valid = 1'b1;
                res_kind  = mcst_pkg::EV_SWITCH;
                res_index = {4'b0000, ctl_sel};
                res_value = {{(mcst_pkg::VALUE_W-1){1'b0}}, d1_q[6]};
              end
              default: begin
                if (d0_q >= mcst_pkg::CC_ALL_OFF_MIN) begin
                  vel_clear = 1'b1;
                  res_valid = 1'b1;
                  res_kind  = mcst_pkg::EV_VEL_CLEAR;
                  res_index = mcst_pkg::AXIS_VEL_BASE;
                end
              end
            endcase
          end
          mcst_pkg::FN_PROGRAM: begin
            prog_wr = 1'b1;
          end
          mcst_pkg::FN_CHAN_PRESS: begin
            prs_fill  = 1'b1;
            res_valid = 1'b1;
            res_kind  = mcst_pkg::EV_AFT_SET;
            res_index = mcst_pkg::AXIS_AFT_BASE;
            res_value = {{PAD_W{1'b0}}, d0_q};
          end
          mcst_pkg::FN_PITCH: begin
            pitch_wr   = 1'b1;
            res_valid  = 1'b1;
            res_index  = mcst_pkg::AXIS_PITCH;
            res_value  = pitch_new;
            res_signed = 1'b1;
          end
          default: begin
          end
        endcase
      end
      mcst_pkg::KIND_READ_AXIS: begin
        res_valid = 1'b1;
        res_kind  = mcst_pkg::EV_READ;
        res_index = ridx_q;
        if (ridx_q < mcst_pkg::AXIS_AFT_BASE) begin
          res_value = {{PAD_W{1'b0}}, vel_rd};
        end else if (ridx_q < mcst_pkg::AXIS_CTL_BASE) begin
          res_value = {{PAD_W{1'b0}}, prs_rd};
        end else if (ridx_q < mcst_pkg::AXIS_PITCH) begin
          res_value  = ctl_cur;
          res_signed = (ctl_sel == mcst_pkg::CTL_BALANCE) ||
                       (ctl_sel == mcst_pkg::CTL_PAN);
        end else begin
          res_value  = pitch_bend;
          res_signed = 1'b1;
        end
      end
      mcst_pkg::KIND_READ_SWITCH: begin
        res_valid = 1'b1;
        res_kind  = mcst_pkg::EV_READ;
        res_index = ridx_q;
        if (ridx_q < mcst_pkg::INDEX_W'(mcst_pkg::CONTROLLER_COUNT)) begin
          res_value = {{(mcst_pkg::VALUE_W-1){1'b0}},
                       sw[ridx_q[mcst_pkg::CTL_AW-1:0]]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mcst_pkg::CONTROLLER_COUNT; i++) begin
        ctl[i] <= '0;
      end
      ctl[mcst_pkg::CTL_VOLUME] <= mcst_pkg::VALUE_FULL;
      sw             <= '0;
      program_number <= '0;
      pitch_bend     <= mcst_pkg::VALUE_CENTRE;
    end else if (cmd.commit) begin
      if (ctl_wr) begin
        ctl[ctl_sel] <= ctl_new;
      end
      if (sw_wr) begin
        sw[ctl_sel] <= d1_q[6];
      end
      if (prog_wr) begin
        program_number <= d0_q;
      end
      if (pitch_wr) begin
        pitch_bend <= pitch_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && res_valid) begin
      event_kind <= res_kind;
      index      <= res_index;
      value      <= res_value;
      centered   <= res_signed;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

`ifndef SYNTHESIS
  a_commit_free_output: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && !out_ready))
    else $error("commit while the output register is still occupied");

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result appeared without a committed item");

  a_group_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !((vel_clear || prs_fill) && (vel_wr || prs_wr)))
    else $error("group fill and single-note write decoded together");
`endif

endmodule

`default_nettype wire

// ===== rtl/midi_channel_state_tracker.sv =====
// Top level of the MIDI channel state tracker.
// Instantiates mcst_ctrl and mcst_datapath; depends on mcst_pkg.
`default_nettype none

// Tracks the state of one MIDI channel from framed voice messages and answers
// read requests for stored axis and switch values. Each accepted item passes
// through a capture step, where the per-note stores are read into their
// output registers, and an apply step, where the state is updated and the
// result, if any, is loaded into the output register. The apply step waits
// while an earlier result has not been taken, and the block takes no new item
// until the apply step is done. Clearing all velocities and setting all
// aftertouch values complete in the apply step; there is no clearing pass
// after reset.
module midi_channel_state_tracker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    kind,
  input  wire logic [7:0]                    status_byte,
  input  wire logic [mcst_pkg::DATA_W-1:0]   data_first,
  input  wire logic [mcst_pkg::DATA_W-1:0]   data_second,
  input  wire logic [1:0]                    byte_count,
  input  wire logic [mcst_pkg::INDEX_W-1:0]  read_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         event_kind,
  output logic [mcst_pkg::INDEX_W-1:0]       index,
  output logic [mcst_pkg::VALUE_W-1:0]       value,
  output logic                               centered
);

  mcst_pkg::mcst_cmd_t    cmd;
  mcst_pkg::mcst_status_t status;

  mcst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mcst_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .kind        (kind),
    .status_byte (status_byte),
    .data_first  (data_first),
    .data_second (data_second),
    .byte_count  (byte_count),
    .read_index  (read_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .index       (index),
    .value       (value),
    .centered    (centered)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for midi_channel_state_tracker.
// It keeps its own model of the channel state and checks every result transfer.
// Depends on mcst_pkg and the RTL of the block only.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcst_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [2:0]         ev_kind;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] val;
    logic               sgn;
  } midi_event_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          kind = KIND_MESSAGE;
  logic [7:0]          status_byte = '0;
  logic [DATA_W-1:0]   data_first = '0;
  logic [DATA_W-1:0]   data_second = '0;
  logic [1:0]          byte_count = 2'd3;
  logic [INDEX_W-1:0]  read_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          event_kind;
  logic [INDEX_W-1:0]  index;
  logic [VALUE_W-1:0]  value;
  logic                centered;

  // Model of the channel state.
  logic [DATA_W-1:0]   note_vel [NOTE_COUNT];
  logic [DATA_W-1:0]   note_aft [NOTE_COUNT];
  logic [VALUE_W-1:0]  ctl_val [CONTROLLER_COUNT];
  logic                switch_on [CONTROLLER_COUNT];
  logic [DATA_W-1:0]   program_num;
  logic [VALUE_W-1:0]  pitch_val;

  midi_event_t pending_events[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          steady_mode = 1'b0;

  midi_channel_state_tracker dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .status_byte (status_byte),
    .data_first  (data_first),
    .data_second (data_second),
    .byte_count  (byte_count),
    .read_index  (read_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .index       (index),
    .value       (value),
    .centered    (centered)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_events.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic ctl_centered(input logic [CTL_AW-1:0] c);
    return (c == CTL_BALANCE) || (c == CTL_PAN);
  endfunction

  task automatic reset_channel_state();
    for (int i = 0; i < NOTE_COUNT; i++) begin
      note_vel[i] = '0;
      note_aft[i] = '0;
    end
    for (int i = 0; i < CONTROLLER_COUNT; i++) begin
      ctl_val[i] = '0;
      switch_on[i] = 1'b0;
    end
    ctl_val[CTL_VOLUME] = VALUE_FULL;
    program_num = '0;
    pitch_val = VALUE_CENTRE;
  endtask

  // Applies one accepted item to the channel state; returns 1 when it yields an event.
  function automatic bit apply_channel_item(input logic [1:0] k, input logic [7:0] st,
                                            input logic [DATA_W-1:0] first,
                                            input logic [DATA_W-1:0] second,
                                            input logic [1:0] bc,
                                            input logic [INDEX_W-1:0] ri,
                                            output midi_event_t ev);
    logic [DATA_W-1:0] d0;
    logic [DATA_W-1:0] d1;
    logic [CTL_AW-1:0] c;
    ev = '0;
    d0 = (bc >= 2'd2) ? first : '0;
    d1 = (bc == 2'd3) ? second : '0;
    c = d0[CTL_AW-1:0];
    if (k == KIND_READ_AXIS) begin
      ev.ev_kind = EV_READ;
      ev.idx = ri;
      if (ri < AXIS_AFT_BASE) begin
        ev.val = VALUE_W'(note_vel[ri[NOTE_AW-1:0]]);
      end else if (ri < AXIS_CTL_BASE) begin
        ev.val = VALUE_W'(note_aft[ri[NOTE_AW-1:0]]);
      end else if (ri < AXIS_PITCH) begin
        ev.val = ctl_val[ri[CTL_AW-1:0]];
        ev.sgn = ctl_centered(ri[CTL_AW-1:0]);
      end else begin
        // Anything past the pitch wheel reads the pitch wheel.
        ev.val = pitch_val;
        ev.sgn = 1'b1;
      end
      return 1'b1;
    end
    if (k == KIND_READ_SWITCH) begin
      ev.ev_kind = EV_READ;
      ev.idx = ri;
      ev.val = (ri < CONTROLLER_COUNT) ? VALUE_W'(switch_on[ri[CTL_AW-1:0]]) : '0;
      return 1'b1;
    end
    if (k != KIND_MESSAGE) return 1'b0;
    case (st[7:4])
      FN_NOTE_OFF: begin
        note_vel[d0] = '0;
        ev.ev_kind = EV_AXIS;
        ev.idx = AXIS_VEL_BASE + d0;
        return 1'b1;
      end
      FN_NOTE_ON: begin
        note_vel[d0] = d1;
        ev.ev_kind = EV_AXIS;
        ev.idx = AXIS_VEL_BASE + d0;
        ev.val = VALUE_W'(d1);
        return 1'b1;
      end
      FN_POLY_PRESS: begin
        note_aft[d0] = d1;
        ev.ev_kind = EV_AXIS;
        ev.idx = AXIS_AFT_BASE + d0;
        ev.val = VALUE_W'(d1);
        return 1'b1;
      end
      FN_CONTROL: begin
        case (d0[6:5]) inside
          CC_MSB, CC_LSB: begin
            if (d0[6:5] == CC_MSB) ctl_val[c] = {d1, ctl_val[c][6:0]};
            else ctl_val[c] = {ctl_val[c][13:7], d1};
            ev.ev_kind = EV_AXIS;
            ev.idx = AXIS_CTL_BASE + c;
            ev.val = ctl_val[c];
            ev.sgn = ctl_centered(c);
            return 1'b1;
          end
          CC_SWITCH: begin
            switch_on[c] = d1[6];
            ev.ev_kind = EV_SWITCH;
            ev.idx = INDEX_W'(c);
            ev.val = VALUE_W'(d1[6]);
            return 1'b1;
          end
          default: begin
            if (d0 < CC_ALL_OFF_MIN) return 1'b0;
            for (int i = 0; i < NOTE_COUNT; i++) note_vel[i] = '0;
            ev.ev_kind = EV_VEL_CLEAR;
            ev.idx = AXIS_VEL_BASE;
            return 1'b1;
          end
        endcase
      end
      FN_PROGRAM: begin
        program_num = d0;
        return 1'b0;
      end
      FN_CHAN_PRESS: begin
        for (int i = 0; i < NOTE_COUNT; i++) note_aft[i] = d0;
        ev.ev_kind = EV_AFT_SET;
        ev.idx = AXIS_AFT_BASE;
        ev.val = VALUE_W'(d0);
        return 1'b1;
      end
      FN_PITCH: begin
        pitch_val = {d1, d0};
        ev.ev_kind = EV_AXIS;
        ev.idx = AXIS_PITCH;
        ev.val = pitch_val;
        ev.sgn = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Result side: random back-pressure and comparison against the oldest expectation.
  always @(posedge clk) begin
    midi_event_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected result: kind %0d index %0d value %0d",
                                    event_kind, index, value));
        end else begin
          want = pending_events.pop_front();
          if (event_kind !== want.ev_kind)
            report_mismatch($sformatf("event_kind got %0d expected %0d", event_kind,
                                      want.ev_kind));
          if (index !== want.idx)
            report_mismatch($sformatf("index got %0d expected %0d", index, want.idx));
          if (value !== want.val)
            report_mismatch($sformatf("value got %0d expected %0d (index %0d)", value,
                                      want.val, want.idx));
          if (centered !== want.sgn)
            report_mismatch($sformatf("centered got %0d expected %0d (index %0d)",
                                      centered, want.sgn, want.idx));
        end
      end
      out_ready <= steady_mode || ($urandom_range(99) >= 32);
    end
  end

  // Offers one item and returns at the edge where the transfer takes place.
  task automatic send_item(input logic [1:0] k, input logic [7:0] st,
                           input logic [DATA_W-1:0] first, input logic [DATA_W-1:0] second,
                           input logic [1:0] bc, input logic [INDEX_W-1:0] ri);
    midi_event_t ev;
    while (!steady_mode && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    status_byte <= st;
    data_first <= first;
    data_second <= second;
    byte_count <= bc;
    read_index <= ri;
    do @(posedge clk); while (!in_ready);
    if (apply_channel_item(k, st, first, second, bc, ri, ev))
      pending_events.insert(pending_events.size(), ev);
  endtask

  task automatic send_msg(input logic [3:0] fn, input logic [DATA_W-1:0] first,
                          input logic [DATA_W-1:0] second, input logic [1:0] bc);
    send_item(KIND_MESSAGE, {fn, 4'($urandom)}, first, second, bc, 9'($urandom));
  endtask

  task automatic send_read(input logic [1:0] k, input logic [INDEX_W-1:0] ri);
    send_item(k, 8'($urandom), 7'($urandom), 7'($urandom), 2'($urandom), ri);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_read(KIND_READ_AXIS, AXIS_VEL_BASE);
    send_read(KIND_READ_AXIS, AXIS_CTL_BASE + CTL_VOLUME);
    send_read(KIND_READ_AXIS, AXIS_CTL_BASE + CTL_PAN);
    send_read(KIND_READ_AXIS, AXIS_PITCH);
    send_read(KIND_READ_AXIS, 9'h1FF);
    send_read(KIND_READ_SWITCH, 9'd0);
    send_read(KIND_READ_SWITCH, 9'h1FF);
  endtask

  task automatic test_voice_messages();
    send_msg(FN_NOTE_ON, 7'd127, 7'd127, 2'd3);
    send_msg(FN_NOTE_ON, 7'd0, 7'd1, 2'd3);
    send_msg(FN_NOTE_OFF, 7'd127, 7'd55, 2'd3);
    send_msg(FN_POLY_PRESS, 7'd127, 7'd127, 2'd3);
    send_msg(FN_CONTROL, 7'd0, 7'd127, 2'd3);
    send_msg(FN_CONTROL, 7'd32, 7'd127, 2'd3);
    send_msg(FN_CONTROL, 7'd8, 7'd64, 2'd3);
    send_msg(FN_CONTROL, 7'd42, 7'd5, 2'd3);
    // Switches flip exactly at a value of 64.
    send_msg(FN_CONTROL, 7'd64, 7'd64, 2'd3);
    send_msg(FN_CONTROL, 7'd95, 7'd63, 2'd3);
    send_msg(FN_CONTROL, 7'd96, 7'd100, 2'd3);
    send_msg(FN_CONTROL, 7'd122, 7'd100, 2'd3);
    send_msg(FN_CONTROL, CC_ALL_OFF_MIN, 7'd0, 2'd3);
    send_msg(FN_CONTROL, 7'd127, 7'd127, 2'd3);
    send_msg(FN_PROGRAM, 7'd99, 7'd0, 2'd2);
    send_msg(FN_CHAN_PRESS, 7'd127, 7'd3, 2'd2);
    send_msg(FN_PITCH, 7'd127, 7'd127, 2'd3);
    send_msg(FN_PITCH, 7'd0, 7'd0, 2'd3);
  endtask

  task automatic test_short_and_ignored();
    // Data bytes past the byte count read as zero; a count of zero acts as one.
    send_msg(FN_NOTE_ON, 7'd90, 7'd80, 2'd1);
    send_msg(FN_NOTE_ON, 7'd90, 7'd80, 2'd0);
    send_msg(FN_PITCH, 7'd5, 7'd127, 2'd2);
    send_item(KIND_MESSAGE, 8'h00, 7'd1, 7'd1, 2'd3, 9'd0);
    send_item(KIND_MESSAGE, 8'hF8, 7'd1, 7'd1, 2'd3, 9'd0);
    send_item(KIND_UNUSED, 8'h90, 7'd1, 7'd1, 2'd3, 9'd0);
    send_read(KIND_READ_AXIS, AXIS_AFT_BASE + 9'd127);
  endtask

  task automatic test_random_traffic(input int count);
    logic [1:0]         k;
    logic [1:0]         bc;
    logic [7:0]         st;
    logic [DATA_W-1:0]  d0;
    logic [DATA_W-1:0]  d1;
    logic [INDEX_W-1:0] ri;
    int                 pick;
    repeat (count) begin
      k = KIND_MESSAGE;
      st = 8'($urandom);
      d0 = 7'($urandom);
      d1 = 7'($urandom);
      bc = 2'd3;
      ri = 9'($urandom);
      pick = $urandom_range(99);
      if (pick < 62) begin
        st[7:4] = 4'($urandom_range(FN_NOTE_OFF, FN_PITCH));
        // Keep notes and controllers in a narrow set half the time so that
        // MSB/LSB pairs meet and later reads hit written entries.
        if ($urandom_range(1) != 0)
          d0 = (st[7:4] == FN_CONTROL) ? 7'($urandom_range(63)) : 7'($urandom_range(15));
        if (pick < 6) bc = 2'($urandom_range(2));
      end else if (pick < 68) begin
        bc = 2'($urandom);
      end else if (pick < 86) begin
        k = KIND_READ_AXIS;
        case ($urandom_range(3))
          0: ri = 9'($urandom_range(15));
          1: ri = AXIS_AFT_BASE + 9'($urandom_range(15));
          2: ri = AXIS_CTL_BASE + 9'($urandom_range(32));
          default: ;
        endcase
      end else if (pick < 96) begin
        k = KIND_READ_SWITCH;
        if ($urandom_range(3) != 0) ri = 9'($urandom_range(31));
      end else begin
        k = KIND_UNUSED;
      end
      send_item(k, st, d0, d1, bc, ri);
    end
  endtask

  task automatic test_steady_stream(input int count);
    steady_mode = 1'b1;
    test_random_traffic(count);
    steady_mode = 1'b0;
  endtask

  initial begin
    reset_channel_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_voice_messages();
    test_short_and_ignored();
    test_random_traffic(400);
    drain_results();
    test_steady_stream(200);
    test_random_traffic(420);
    drain_results();
    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_events.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
